### hdl/vdt_pkg.sv
// shared types for the vertex deduplication table
`default_nettype none

package vdt_pkg;

   localparam int COORD_W = 32;
   localparam int INDEX_W = 8;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   typedef struct packed {
      logic                      opcode;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
   } vdt_req_type;

   typedef struct packed {
      logic [INDEX_W-1:0]        vertex_index;
      logic                      found_existing;
      logic                      table_full;
      logic signed [COORD_W-1:0] box_min_x;
      logic signed [COORD_W-1:0] box_min_y;
      logic signed [COORD_W-1:0] box_min_z;
      logic signed [COORD_W-1:0] box_max_x;
      logic signed [COORD_W-1:0] box_max_y;
      logic signed [COORD_W-1:0] box_max_z;
   } vdt_rsp_type;

   typedef struct packed {
      logic load;
      logic scan_run;
      logic reply_hit;
      logic reply_full;
      logic append;
      logic clear;
   } vdt_cmd_type;

   typedef struct packed {
      logic clear_req;
      logic hit;
      logic miss_done;
      logic full;
   } vdt_status_type;

endpackage

`default_nettype wire

### hdl/vdt_ctrl.sv
// controller state machine for the vertex deduplication table
`default_nettype none

module vdt_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire vdt_pkg::vdt_status_type status,
   output vdt_pkg::vdt_cmd_type         cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (status.clear_req) begin
                  cmd.clear = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (status.hit) begin
               cmd.reply_hit = 1'b1;
               state_in      = ST_IDLE;
            end else if (status.miss_done) begin
               // no match anywhere: store the point unless there is no room
               if (status.full) begin
                  cmd.reply_full = 1'b1;
               end else begin
                  cmd.append = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

### hdl/vdt_datapath.sv
// vertex store, pipelined search, vertex count and bounding box
`default_nettype none

module vdt_datapath #(
   parameter int VERTEX_DEPTH = 256
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire vdt_pkg::vdt_req_type req_payload,
   input  wire vdt_pkg::vdt_cmd_type cmd,
   output vdt_pkg::vdt_status_type   status,
   output logic                      rsp_strobe,
   output vdt_pkg::vdt_rsp_type      rsp_payload
);

   localparam int AW = $clog2(VERTEX_DEPTH);
   localparam int CW = AW + 1;
   localparam int PW = 3 * vdt_pkg::COORD_W;

   logic [PW-1:0] vertex_mem [VERTEX_DEPTH];

   vdt_pkg::vdt_req_type req_ff;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        scan_addr_ff, scan_addr_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic [AW-1:0]        rd_idx_ff;
   logic [PW-1:0]        rd_data_ff;
   logic                 rd_en;

   logic signed [vdt_pkg::COORD_W-1:0] low_ff [3];
   logic signed [vdt_pkg::COORD_W-1:0] low_in [3];
   logic signed [vdt_pkg::COORD_W-1:0] high_ff [3];
   logic signed [vdt_pkg::COORD_W-1:0] high_in [3];
   logic signed [vdt_pkg::COORD_W-1:0] pt [3];

   logic                       rsp_strobe_ff, rsp_strobe_in;
   logic [vdt_pkg::INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic                       rsp_found_ff;
   logic                       rsp_full_ff;

   logic [PW-1:0] key;
   logic          match;

   assign pt[0] = req_ff.point_x;
   assign pt[1] = req_ff.point_y;
   assign pt[2] = req_ff.point_z;
   assign key   = {req_ff.point_x, req_ff.point_y, req_ff.point_z};
   assign match = (rd_data_ff == key);

   assign status.clear_req = (req_payload.opcode == vdt_pkg::OP_CLEAR);
   assign status.hit       = rd_valid_ff && match;
   assign status.miss_done = (scan_addr_ff == count_ff) && !rd_valid_ff;
   assign status.full      = (count_ff == CW'(VERTEX_DEPTH));

   // one read issued per cycle; the read data is registered, then compared against the key
   assign rd_en       = cmd.scan_run && (scan_addr_ff < count_ff);
   assign rd_valid_in = rd_en;

   always_comb begin
      scan_addr_in = scan_addr_ff;
      if (cmd.load) begin
         scan_addr_in = '0;
      end else if (rd_en) begin
         scan_addr_in = scan_addr_ff + CW'(1);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.append) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         low_in[i]  = low_ff[i];
         high_in[i] = high_ff[i];
         if (cmd.clear) begin
            low_in[i]  = '0;
            high_in[i] = '0;
         end else if (cmd.append) begin
            if (count_ff == '0) begin
               low_in[i]  = pt[i];
               high_in[i] = pt[i];
            end else begin
               if (pt[i] < low_ff[i]) begin
                  low_in[i] = pt[i];
               end
               if (high_ff[i] < pt[i]) begin
                  high_in[i] = pt[i];
               end
            end
         end
      end
   end

   assign rsp_strobe_in = cmd.clear || cmd.reply_hit || cmd.reply_full || cmd.append;

   always_comb begin
      rsp_index_in = '0;
      if (cmd.reply_hit) begin
         rsp_index_in = vdt_pkg::INDEX_W'(rd_idx_ff);
      end else if (cmd.append) begin
         rsp_index_in = vdt_pkg::INDEX_W'(count_ff[AW-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.append) begin
         vertex_mem[count_ff[AW-1:0]] <= key;
      end
      if (rd_en) begin
         rd_data_ff <= vertex_mem[scan_addr_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_payload;
      end
      if (rd_en) begin
         rd_idx_ff <= scan_addr_ff[AW-1:0];
      end
      rsp_index_ff <= rsp_index_in;
      rsp_found_ff <= cmd.reply_hit;
      rsp_full_ff  <= cmd.reply_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         scan_addr_ff  <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            low_ff[i]  <= '0;
            high_ff[i] <= '0;
         end
      end else begin
         count_ff      <= count_in;
         scan_addr_ff  <= scan_addr_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
         for (int i = 0; i < 3; i++) begin
            low_ff[i]  <= low_in[i];
            high_ff[i] <= high_in[i];
         end
      end
   end

   // box fields read the corners directly; they hold through the strobe cycle
   assign rsp_strobe                 = rsp_strobe_ff;
   assign rsp_payload.vertex_index   = rsp_index_ff;
   assign rsp_payload.found_existing = rsp_found_ff;
   assign rsp_payload.table_full     = rsp_full_ff;
   assign rsp_payload.box_min_x      = low_ff[0];
   assign rsp_payload.box_min_y      = low_ff[1];
   assign rsp_payload.box_min_z      = low_ff[2];
   assign rsp_payload.box_max_x      = high_ff[0];
   assign rsp_payload.box_max_y      = high_ff[1];
   assign rsp_payload.box_max_z      = high_ff[2];

endmodule

`default_nettype wire

### hdl/vertex_dedup_table_core.sv
// vertex deduplication table: insert finds or appends a point, clear empties the table
// insert miss: every stored vertex is compared, then the point is appended and strobed;
//   hit: strobes its index; the search reads one stored vertex per cycle from one memory port
// clear: strobe the cycle after acceptance, busy stays low
// one transaction at a time; busy is high while a search runs, results cannot be stalled
// synchronous reset empties the table and zeros the box; memory contents are not cleared
`default_nettype none

module vertex_dedup_table_core #(
   parameter int VERTEX_DEPTH = 256
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire vdt_pkg::vdt_req_type req_payload,
   output logic                      rsp_strobe,
   output vdt_pkg::vdt_rsp_type      rsp_payload
);

   vdt_pkg::vdt_cmd_type    cmd;
   vdt_pkg::vdt_status_type status;

   vdt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   vdt_datapath #(
      .VERTEX_DEPTH (VERTEX_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
